### design/ipv4p_pkg.sv
package ipv4p_pkg;

  localparam int MAX_FIELD_DIGITS_DEF = 31;
  localparam int BUDGET_W = 16;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd256;

  localparam logic [1:0] STATUS_VALID   = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_IGNORE  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_HT    = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] address;
  } out_beat_t;

endpackage

### design/ipv4_text_line_parser_top.sv
// Output: a result beat is registered at the clock edge that accepts the byte deciding it,
// into the output register, or into the skid register while the output register is stalled.
// Throughput: one text byte per cycle while in_stall is low; the line state and a single
// multiply-by-ten update together in that cycle, and a one-entry skid stage lets input
// continue while a result waits. Reset (synchronous, active low): budget register returns
// to 256, the parser waits for the start of a line, and no result is pending.
module ipv4_text_line_parser_top
  import ipv4p_pkg::*;
#(
  parameter int MAX_FIELD_DIGITS = MAX_FIELD_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_beat_t            in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output out_beat_t           out_beat,
  input  logic                cfg_wr_en,
  input  logic [BUDGET_W-1:0] cfg_wr_data
);

  localparam int DC_W = $clog2(MAX_FIELD_DIGITS + 1);

  typedef enum logic [2:0] {
    PH_START, PH_SPACE, PH_F1, PH_F2, PH_F3, PH_F4, PH_DONE
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [BUDGET_W-1:0] budget_r, budget_nxt;
  logic [DC_W-1:0]     digit_count_r, digit_count_nxt;
  logic [7:0]          field_value_r, field_value_nxt;
  logic                field_too_big_r, field_too_big_nxt;
  logic [23:0]         addr_r, addr_nxt;
  logic [BUDGET_W-1:0] max_line_bytes_r;

  out_beat_t out_r, skid_r;
  logic      out_valid_r, skid_valid_r;

  phase_t              p0, p1, q;
  logic [BUDGET_W-1:0] b0, b1;
  logic [DC_W-1:0]     dc0, dc1;
  logic [7:0]          fv0, fv1;
  logic                tb0, tb1;
  logic [23:0]         addr0, addr1;
  logic                go_field;
  logic                r1_v, r2_v, res_v;
  logic [1:0]          r1_st, r2_st;
  logic [31:0]         r1_addr, r2_addr;
  out_beat_t           res;
  logic [7:0]          c;
  logic                is_ws, is_digit;
  logic [11:0]         prod;
  logic                acc, out_fire;

  assign acc      = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign c        = in_beat.char_byte;
  assign is_ws    = (c == CH_SPACE) || (c inside {[CH_HT:CH_CR]});
  assign is_digit = c inside {[CH_ZERO:CH_NINE]};
  assign prod     = {4'd0, fv0} * 12'd10 + {8'd0, c[3:0]};

  always_comb begin
    if (phase_r == PH_START) begin
      p0    = PH_SPACE;
      b0    = max_line_bytes_r;
      dc0   = '0;
      fv0   = '0;
      tb0   = 1'b0;
      addr0 = '0;
    end else begin
      p0    = phase_r;
      b0    = budget_r;
      dc0   = digit_count_r;
      fv0   = field_value_r;
      tb0   = field_too_big_r;
      addr0 = addr_r;
    end
  end

  always_comb begin
    p1       = p0;
    b1       = b0;
    dc1      = dc0;
    fv1      = fv0;
    tb1      = tb0;
    addr1    = addr0;
    r1_v     = 1'b0;
    r1_st    = STATUS_VALID;
    r1_addr  = '0;
    go_field = 1'b0;
    q        = p0;
    if (p0 == PH_SPACE) begin
      if (b0 == '0) begin
        r1_v  = 1'b1;
        r1_st = STATUS_IGNORE;
      end else if (is_ws) begin
        b1 = b0 - 1'b1;
      end else if (c == CH_NUL) begin
        r1_v  = 1'b1;
        r1_st = STATUS_IGNORE;
      end else begin
        go_field = 1'b1;
        q        = PH_F1;
        p1       = PH_F1;
      end
    end else if (p0 inside {PH_F1, PH_F2, PH_F3, PH_F4}) begin
      go_field = 1'b1;
    end
    if (go_field) begin
      if (b0 == '0) begin
        r1_v  = 1'b1;
        r1_st = STATUS_INVALID;
      end else if (q != PH_F4 && c == CH_DOT) begin
        if (dc0 == '0 || tb0) begin
          r1_v  = 1'b1;
          r1_st = STATUS_INVALID;
        end else begin
          addr1 = {addr0[15:0], fv0};
          dc1   = '0;
          fv1   = '0;
          tb1   = 1'b0;
          case (q)
            PH_F1:   p1 = PH_F2;
            PH_F2:   p1 = PH_F3;
            default: p1 = PH_F4;
          endcase
        end
      end else if (q == PH_F4 && (c == CH_NUL || is_ws)) begin
        r1_v = 1'b1;
        if (dc0 == '0 || tb0) begin
          r1_st = STATUS_INVALID;
        end else begin
          r1_st   = STATUS_VALID;
          r1_addr = {addr0, fv0};
        end
      end else if (!is_digit || dc0 >= DC_W'(MAX_FIELD_DIGITS)) begin
        r1_v  = 1'b1;
        r1_st = STATUS_INVALID;
      end else begin
        if (!tb0) begin
          if (prod > 12'd255) begin
            tb1 = 1'b1;
            fv1 = 8'd255;
          end else begin
            fv1 = prod[7:0];
          end
        end
        dc1 = dc0 + 1'b1;
        b1  = b0 - 1'b1;
      end
    end
  end

  // The end of a line acts as a NUL byte fed right after the last byte.
  always_comb begin
    r2_v    = 1'b0;
    r2_st   = STATUS_VALID;
    r2_addr = '0;
    if (!r1_v && in_beat.line_end) begin
      case (p1)
        PH_SPACE: begin
          r2_v  = 1'b1;
          r2_st = STATUS_IGNORE;
        end
        PH_F1, PH_F2, PH_F3: begin
          r2_v  = 1'b1;
          r2_st = STATUS_INVALID;
        end
        PH_F4: begin
          r2_v = 1'b1;
          if (b1 == '0 || dc1 == '0 || tb1) begin
            r2_st = STATUS_INVALID;
          end else begin
            r2_st   = STATUS_VALID;
            r2_addr = {addr1, fv1};
          end
        end
        default: r2_v = 1'b0;
      endcase
    end
  end

  always_comb begin
    res_v       = r1_v || r2_v;
    res.status  = r1_v ? r1_st : r2_st;
    res.address = r1_v ? r1_addr : r2_addr;
    if (in_beat.line_end) begin
      phase_nxt = PH_START;
    end else if (res_v) begin
      phase_nxt = PH_DONE;
    end else begin
      phase_nxt = p1;
    end
    budget_nxt        = b1;
    digit_count_nxt   = dc1;
    field_value_nxt   = fv1;
    field_too_big_nxt = tb1;
    addr_nxt          = addr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_START;
      max_line_bytes_r <= BUDGET_RESET;
    end else begin
      if (cfg_wr_en) begin
        max_line_bytes_r <= cfg_wr_data;
      end
      if (acc) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      budget_r        <= budget_nxt;
      digit_count_r   <= digit_count_nxt;
      field_value_r   <= field_value_nxt;
      field_too_big_r <= field_too_big_nxt;
      addr_r          <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (acc && res_v) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid stage filled without a stalled output beat");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != STATUS_VALID |-> out_r.address == '0)
    else $error("non-valid result carries a nonzero address");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    acc && phase_r == PH_DONE |-> !res_v)
    else $error("result produced after the line was already decided");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.status == STATUS_VALID || out_r.status == STATUS_INVALID ||
                     out_r.status == STATUS_IGNORE))
    else $error("output status code out of range");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import ipv4p_pkg::*;

  localparam int NO_RESULT = -1;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] NUL_MARK = "#";

  typedef enum logic [2:0] {
    LP_START, LP_SPACE, LP_F1, LP_F2, LP_F3, LP_F4, LP_DONE
  } line_phase_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_beat;
  logic out_valid;
  logic out_stall;
  out_beat_t out_beat;
  logic cfg_wr_en;
  logic [BUDGET_W-1:0] cfg_wr_data;

  ipv4_text_line_parser_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  line_phase_t lp_phase;
  logic [15:0] budget_cfg;
  logic [15:0] bytes_left;
  int field_digits;
  logic [8:0] field_val;
  bit field_over;
  logic [23:0] octets_seen;
  logic [31:0] addr_done;

  out_beat_t addr_expect_q[$];
  logic [7:0] line_bytes[$];
  string row_text[$];
  logic [15:0] row_budget[$];
  bit row_typed[$];
  out_beat_t row_want[$];

  int errors = 0;
  int cycles = 0;
  int bytes_sent = 0;
  int n_valid = 0;
  int n_invalid = 0;
  int n_ignore = 0;
  int n_cfg = 0;
  int hold_req = 0;
  bit no_idle = 1'b0;
  out_beat_t want_beat;

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_HT && c <= CH_CR);
  endfunction

  function automatic void clear_field();
    field_digits = 0;
    field_val = '0;
    field_over = 1'b0;
  endfunction

  function automatic int take_digit(logic [7:0] c);
    int v;
    if (c < CH_ZERO || c > CH_NINE) return int'(STATUS_INVALID);
    if (field_digits >= MAX_FIELD_DIGITS_DEF) return int'(STATUS_INVALID);
    if (!field_over) begin
      v = int'(field_val) * 10 + int'(c - CH_ZERO);
      if (v > 255) begin
        field_over = 1'b1;
        field_val = 9'd255;
      end else begin
        field_val = v[8:0];
      end
    end
    field_digits++;
    bytes_left = bytes_left - 16'd1;
    return NO_RESULT;
  endfunction

  function automatic int parse_char(logic [7:0] c);
    if (lp_phase == LP_SPACE) begin
      if (bytes_left == 0) return int'(STATUS_IGNORE);
      if (is_space(c)) begin
        bytes_left = bytes_left - 16'd1;
        return NO_RESULT;
      end
      if (c == CH_NUL) return int'(STATUS_IGNORE);
      lp_phase = LP_F1;
    end
    if (lp_phase inside {LP_F1, LP_F2, LP_F3}) begin
      if (bytes_left == 0) return int'(STATUS_INVALID);
      if (c == CH_DOT) begin
        if (field_digits == 0 || field_over) return int'(STATUS_INVALID);
        octets_seen = {octets_seen[15:0], field_val[7:0]};
        clear_field();
        lp_phase = line_phase_t'(lp_phase + 3'd1);
        return NO_RESULT;
      end
      return take_digit(c);
    end
    if (lp_phase == LP_F4) begin
      if (bytes_left == 0) return int'(STATUS_INVALID);
      if (c == CH_NUL || is_space(c)) begin
        if (field_digits == 0 || field_over) return int'(STATUS_INVALID);
        addr_done = {octets_seen, field_val[7:0]};
        return int'(STATUS_VALID);
      end
      return take_digit(c);
    end
    return NO_RESULT;
  endfunction

  function automatic bit predict_address(input in_beat_t b, output out_beat_t r);
    int code;
    if (lp_phase == LP_START) begin
      bytes_left = budget_cfg;
      clear_field();
      octets_seen = '0;
      addr_done = '0;
      lp_phase = LP_SPACE;
    end
    code = NO_RESULT;
    if (lp_phase != LP_DONE) begin
      code = parse_char(b.char_byte);
      if (code == NO_RESULT && b.line_end) code = parse_char(CH_NUL);
    end
    if (b.line_end) lp_phase = LP_START;
    else if (code != NO_RESULT) lp_phase = LP_DONE;
    r.status = code[1:0];
    r.address = (code == int'(STATUS_VALID)) ? addr_done : 32'd0;
    return code != NO_RESULT;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] ws_char();
    if ($urandom_range(0, 2) == 0) return CH_SPACE;
    return CH_HT + 8'($urandom_range(0, 4));
  endfunction

  task automatic send_beat(in_beat_t b, bit typed, out_beat_t want);
    int gap;
    bit hit;
    out_beat_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    hit = predict_address(b, pred);
    if (hit) addr_expect_q.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  task automatic send_line(bit typed, out_beat_t want);
    in_beat_t b;
    for (int i = 0; i < line_bytes.size(); i++) begin
      b.char_byte = line_bytes[i];
      b.line_end = (i == line_bytes.size() - 1);
      send_beat(b, typed, want);
    end
  endtask

  task automatic set_budget(logic [15:0] v);
    in_valid <= 1'b0;
    while (addr_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    budget_cfg = v;
    n_cfg++;
  endtask

  task automatic add_row(string s, logic [15:0] budget, bit typed, logic [1:0] st,
                         logic [31:0] addr);
    out_beat_t w;
    w.status = st;
    w.address = addr;
    row_text.push_back(s);
    row_budget.push_back(budget);
    row_typed.push_back(typed);
    row_want.push_back(w);
  endtask

  task automatic build_line();
    int kind;
    int n;
    int v;
    int pad;
    int term;
    string s;
    line_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 65) begin
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) line_bytes.push_back(ws_char());
      for (int f = 0; f < 4; f++) begin
        v = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 999) : $urandom_range(0, 255);
        if ($urandom_range(0, 29) == 0) pad = $urandom_range(26, 32);
        else pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (pad) line_bytes.push_back(CH_ZERO);
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
        if (f < 3) line_bytes.push_back(CH_DOT);
      end
      term = $urandom_range(0, 2);
      if (term == 0) line_bytes.push_back(ws_char());
      else if (term == 1) line_bytes.push_back(CH_NUL);
      repeat ($urandom_range(0, 4)) line_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 6) == 0)
        line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0)
        while (line_bytes.size() > 1 && $urandom_range(0, 3) != 0) void'(line_bytes.pop_back());
    end else if (kind < 80) begin
      repeat ($urandom_range(0, 4)) line_bytes.push_back(ws_char());
      if ($urandom_range(0, 1) == 0) begin
        line_bytes.push_back(CH_NUL);
        repeat ($urandom_range(0, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (line_bytes.size() == 0) line_bytes.push_back(ws_char());
    end else begin
      repeat ($urandom_range(1, 10)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, addr_expect_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (addr_expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got status %0d address %h",
                 $time, out_beat.status, out_beat.address);
      end else begin
        want_beat = addr_expect_q.pop_front();
        if (out_beat.status !== want_beat.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want_beat.status, out_beat.status);
        end
        if (out_beat.address !== want_beat.address) begin
          errors++;
          $display("%0t: address mismatch, expected %h, got %h",
                   $time, want_beat.address, out_beat.address);
        end
        case (want_beat.status)
          STATUS_VALID: n_valid++;
          STATUS_INVALID: n_invalid++;
          default: n_ignore++;
        endcase
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (no_idle || $urandom_range(0, 99) >= 15) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 3);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] phase_budget[8];
    int phase_bytes[8];
    int start_count;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_beat = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    lp_phase = LP_START;
    budget_cfg = BUDGET_RESET;

    // A '#' in a row's text stands for a NUL byte. The last byte of each row ends the line.
    add_row("255.255.255.255 ", 16'd256, 1, STATUS_VALID, 32'hFFFF_FFFF);
    add_row("0.0.0.0", 16'd256, 1, STATUS_VALID, 32'h0000_0000);
    add_row(" \t\n\013\014\r", 16'd256, 1, STATUS_IGNORE, 32'd0);
    add_row("#", 16'd256, 1, STATUS_IGNORE, 32'd0);
    add_row("1.2.3.4#xyz", 16'd256, 1, STATUS_VALID, 32'h0102_0304);
    add_row("  10.20.30.40\r", 16'd256, 1, STATUS_VALID, 32'h0A14_1E28);
    add_row("1.2.3", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("1..2.3.4", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("256.1.1.1 ", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("1.2.3.999", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("a.1.1.1", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("1.2.3.4a", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("1.2.3.4.", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("1.2#.3.4", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("\377", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("\200.1", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("0000000000000000000000000000000.1.1.1 ", 16'd256, 1, STATUS_VALID, 32'h0001_0101);
    add_row("00000000000000000000000000000000.1.1.1 ", 16'd256, 1, STATUS_INVALID, 32'd0);
    add_row("007.08.9.0010 1.1", 16'd256, 0, STATUS_VALID, 32'd0);
    add_row(" 1.2.3.4", 16'd0, 1, STATUS_IGNORE, 32'd0);
    add_row("   ", 16'd2, 1, STATUS_IGNORE, 32'd0);
    add_row("  1.2", 16'd3, 1, STATUS_INVALID, 32'd0);
    add_row("1.2.3.4 ", 16'd4, 1, STATUS_INVALID, 32'd0);
    add_row("1.2.3.4 ", 16'd7, 1, STATUS_VALID, 32'h0102_0304);
    add_row("192.168.0.1", 16'hFFFF, 0, STATUS_VALID, 32'd0);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < row_text.size(); r++) begin
      if (row_budget[r] != budget_cfg) set_budget(row_budget[r]);
      line_bytes.delete();
      for (int i = 0; i < row_text[r].len(); i++)
        line_bytes.push_back(row_text[r][i] == NUL_MARK ? CH_NUL : row_text[r][i]);
      send_line(row_typed[r], row_want[r]);
    end

    phase_budget = '{BUDGET_RESET, 16'hFFFF, 16'hFFFF, 16'($urandom_range(20, 60)),
                     16'($urandom_range(0, 65535)), 16'd0, 16'd1, 16'd9};
    phase_bytes = '{40, 30, 50, 30, 30, 10, 10, 30};
    for (int p = 0; p < 8; p++) begin
      set_budget(phase_budget[p]);
      no_idle = (p == 1);
      if (p == 2) hold_req = 150;
      start_count = bytes_sent;
      while (bytes_sent - start_count < phase_bytes[p]) begin
        build_line();
        send_line(1'b0, '0);
        if (p == 3 && bytes_sent - start_count >= phase_bytes[p] / 2
            && addr_expect_q.size() != 0) begin
          in_valid <= 1'b0;
          while (addr_expect_q.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (addr_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d text bytes under %0d budget writes; results: %0d valid, %0d invalid,",
             bytes_sent, n_cfg, n_valid, n_invalid);
    $display("%0d ignored; %0d mismatches.", n_ignore, errors);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
